[hw/rtl/ubd_pkg.sv]
// Shared types and constants for the UTF-8 byte stream decoder.
package ubd_pkg;

    // Field widths
    localparam int unsigned CODE_W   = 31;
    localparam int unsigned BITS_W   = 5;
    localparam int unsigned OCTET_W  = 8;
    localparam int unsigned PEND_W   = 3;
    localparam int unsigned PAY_W    = 7;

    // Default depth of the queue between front and back
    localparam int unsigned UBD_FIFO_DEPTH = 4;

    // Replacement values and limits
    localparam logic [CODE_W-1:0] ERR_NARROW = 31'h0000_003F;  // '?'
    localparam logic [CODE_W-1:0] ERR_WIDE   = 31'h0000_FFFD;
    localparam logic [CODE_W-1:0] BMP_MAX    = 31'h0000_FFFF;
    localparam logic [BITS_W-1:0] ASCII_BITS = 5'd7;

    // Configuration register indexes
    localparam logic CFG_WIDE_MODE = 1'b0;
    localparam logic CFG_CONT_ERR  = 1'b1;

    // Byte class as seen outside of a sequence
    typedef enum logic [1:0] {
        K_ASCII,     // 0xxxxxxx
        K_CONT,      // 10xxxxxx
        K_LEAD,      // 110xxxxx .. 1111110x
        K_BAD_LEAD   // 0xFE, 0xFF
    } t_kind;

    // One classified byte as it travels through the queue
    typedef struct packed {
        t_kind              kind;
        logic [PAY_W-1:0]   payload;   // ascii value, continuation or lead payload bits
        logic [PEND_W-1:0]  pend_init; // continuations a lead byte announces
        logic [BITS_W-1:0]  seq_bits;  // payload bits of the whole sequence
        logic               eos;
    } t_item;

endpackage

[hw/rtl/utf8_byte_stream_decoder.sv]
// Top level of the UTF-8 byte stream decoder.
// Decodes one byte per cycle while the output is not stalled: a byte word is
// taken into a FIFO_DEPTH-entry queue in the cycle it arrives, the decode
// stage consumes one queued word per clock and registers its result, so a
// result passes the queue entry and then the output register. The sequence
// update sets the rate; the queue and the output register let the input keep
// flowing for FIFO_DEPTH words while the output is stalled. The user must
// write configuration (wide_mode at index 0, continue_on_error at index 1)
// through i_cfg_we only while no string is in flight; nothing here enforces it.
module utf8_byte_stream_decoder #(
    parameter int unsigned FIFO_DEPTH = ubd_pkg::UBD_FIFO_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic                          i_cfg_wdata,
    // byte input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ubd_pkg::OCTET_W-1:0]   i_octet,
    input  logic                          i_end_of_string,
    // decoded output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ubd_pkg::CODE_W-1:0]    o_code,
    output logic                          o_ok,
    output logic [ubd_pkg::BITS_W-1:0]    o_bit_count
);

    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    ubd_pkg::t_item  wr_item;
    ubd_pkg::t_item  rd_item;

    ubd_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_octet         (i_octet),
        .i_end_of_string (i_end_of_string),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_item          (wr_item)
    );

    ubd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (wr_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (rd_item)
    );

    ubd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_item      (rd_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_code      (o_code),
        .o_ok        (o_ok),
        .o_bit_count (o_bit_count)
    );

endmodule

[hw/rtl/ubd_front.sv]
// Input side: takes byte words and classifies each into a queue entry.
module ubd_front (
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ubd_pkg::OCTET_W-1:0]   i_octet,
    input  logic                          i_end_of_string,
    input  logic                          i_q_full,
    output logic                          o_push,
    output ubd_pkg::t_item                o_item
);

    // Handshake: stall only when the queue has no room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    // Classify by counting leading ones of the byte
    always_comb begin
        o_item           = '0;
        o_item.eos       = i_end_of_string;
        o_item.kind      = ubd_pkg::K_BAD_LEAD;
        priority if (!i_octet[7]) begin
            o_item.kind    = ubd_pkg::K_ASCII;
            o_item.payload = i_octet[6:0];
        end else if (!i_octet[6]) begin
            o_item.kind    = ubd_pkg::K_CONT;
            o_item.payload = {1'b0, i_octet[5:0]};
        end else if (!i_octet[5]) begin
            o_item.kind      = ubd_pkg::K_LEAD;
            o_item.payload   = {2'b0, i_octet[4:0]};
            o_item.pend_init = 3'd1;
            o_item.seq_bits  = 5'd11;
        end else if (!i_octet[4]) begin
            o_item.kind      = ubd_pkg::K_LEAD;
            o_item.payload   = {3'b0, i_octet[3:0]};
            o_item.pend_init = 3'd2;
            o_item.seq_bits  = 5'd16;
        end else if (!i_octet[3]) begin
            o_item.kind      = ubd_pkg::K_LEAD;
            o_item.payload   = {4'b0, i_octet[2:0]};
            o_item.pend_init = 3'd3;
            o_item.seq_bits  = 5'd21;
        end else if (!i_octet[2]) begin
            o_item.kind      = ubd_pkg::K_LEAD;
            o_item.payload   = {5'b0, i_octet[1:0]};
            o_item.pend_init = 3'd4;
            o_item.seq_bits  = 5'd26;
        end else if (!i_octet[1]) begin
            o_item.kind      = ubd_pkg::K_LEAD;
            o_item.payload   = {6'b0, i_octet[0]};
            o_item.pend_init = 3'd5;
            o_item.seq_bits  = 5'd31;
        end else begin
            o_item.kind = ubd_pkg::K_BAD_LEAD;
        end
    end

endmodule

[hw/rtl/ubd_fifo.sv]
// Short queue of classified bytes between front and back.
module ubd_fifo #(
    parameter int unsigned DEPTH = ubd_pkg::UBD_FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ubd_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output ubd_pkg::t_item  o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ubd_pkg::t_item     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer wrap and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hw/rtl/ubd_back.sv]
// Decode side: sequence state, configuration and the output register.
module ubd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic                          i_cfg_wdata,
    // queue side
    input  logic                          i_q_empty,
    input  ubd_pkg::t_item                i_item,
    output logic                          o_pop,
    // result side
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ubd_pkg::CODE_W-1:0]    o_code,
    output logic                          o_ok,
    output logic [ubd_pkg::BITS_W-1:0]    o_bit_count
);

    logic                          r_wide_mode;
    logic                          r_cont_err;

    logic [ubd_pkg::PEND_W-1:0]    r_pend, n_pend;
    logic [ubd_pkg::CODE_W-1:0]    r_acc, n_acc;
    logic [ubd_pkg::BITS_W-1:0]    r_seq, n_seq;
    logic [ubd_pkg::PEND_W-1:0]    r_skip, n_skip;
    logic                          r_halted, n_halted;

    logic                          r_out_valid;
    logic [ubd_pkg::CODE_W-1:0]    r_code;
    logic                          r_ok;
    logic [ubd_pkg::BITS_W-1:0]    r_bits;

    logic                          emit_chr;
    logic                          err;
    logic [ubd_pkg::CODE_W-1:0]    chr_val;
    logic [ubd_pkg::BITS_W-1:0]    chr_bits;
    logic [ubd_pkg::CODE_W-1:0]    res_code;
    logic                          res_ok;
    logic [ubd_pkg::BITS_W-1:0]    res_bits;
    logic                          res_valid;

    // Take a word whenever the output register is free or draining
    assign o_pop = ~i_q_empty & (~r_out_valid | ~i_out_stall);

    // Sequence decode, one queue word per cycle unless the output register is held
    always_comb begin
        n_pend   = r_pend;
        n_acc    = r_acc;
        n_seq    = r_seq;
        n_skip   = r_skip;
        n_halted = r_halted;
        emit_chr = 1'b0;
        err      = 1'b0;
        chr_val  = r_acc;
        chr_bits = r_seq;

        priority if (r_halted) begin
            // drop until end of string
        end else if (r_skip != '0) begin
            n_skip = r_skip - 1'b1;
        end else if (r_pend != '0) begin
            if (i_item.kind == ubd_pkg::K_CONT) begin
                n_acc  = {r_acc[ubd_pkg::CODE_W-7:0], i_item.payload[5:0]};
                n_pend = r_pend - 1'b1;
                if (n_pend == '0) begin
                    emit_chr = 1'b1;
                    chr_val  = n_acc;
                end else if (i_item.eos) begin
                    err = 1'b1;
                end
            end else begin
                // bad continuation eats the rest of the nominal length
                n_skip = r_pend - 1'b1;
                n_pend = '0;
                err    = 1'b1;
            end
        end else begin
            unique case (i_item.kind)
                ubd_pkg::K_ASCII: begin
                    emit_chr = 1'b1;
                    chr_val  = ubd_pkg::CODE_W'(i_item.payload);
                    chr_bits = ubd_pkg::ASCII_BITS;
                end
                ubd_pkg::K_LEAD: begin
                    n_acc  = ubd_pkg::CODE_W'(i_item.payload);
                    n_seq  = i_item.seq_bits;
                    n_pend = i_item.pend_init;
                    err    = i_item.eos;
                end
                ubd_pkg::K_CONT, ubd_pkg::K_BAD_LEAD: begin
                    err = 1'b1;
                end
                default: begin
                    err = 1'b1;
                end
            endcase
        end

        if (err && !r_cont_err) begin
            n_halted = 1'b1;
        end

        // end of string clears all sequence state
        if (i_item.eos) begin
            n_pend   = '0;
            n_acc    = '0;
            n_seq    = '0;
            n_skip   = '0;
            n_halted = 1'b0;
        end
    end

    // Result formatting for the selected output mode
    always_comb begin
        res_valid = emit_chr | (err & r_cont_err);
        res_code  = chr_val;
        res_ok    = 1'b1;
        res_bits  = chr_bits;
        if (emit_chr) begin
            if (r_wide_mode && chr_val > ubd_pkg::BMP_MAX) begin
                res_code = ubd_pkg::ERR_WIDE;
            end
        end else begin
            res_code = r_wide_mode ? ubd_pkg::ERR_WIDE : ubd_pkg::ERR_NARROW;
            res_ok   = 1'b0;
            res_bits = '0;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= 1'b0;
            r_cont_err  <= 1'b0;
            r_pend      <= '0;
            r_acc       <= '0;
            r_seq       <= '0;
            r_skip      <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ubd_pkg::CFG_WIDE_MODE: r_wide_mode <= i_cfg_wdata;
                    ubd_pkg::CFG_CONT_ERR:  r_cont_err  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (o_pop) begin
                r_pend      <= n_pend;
                r_acc       <= n_acc;
                r_seq       <= n_seq;
                r_skip      <= n_skip;
                r_halted    <= n_halted;
                r_out_valid <= res_valid;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop && res_valid) begin
            r_code <= res_code;
            r_ok   <= res_ok;
            r_bits <= res_bits;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_code      = r_code;
    assign o_ok        = r_ok;
    assign o_bit_count = r_bits;

    // Skipping and collecting continuations never overlap
    a_skip_pend_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_skip != '0 && r_pend != '0))
        else $error("skip and pending counts both nonzero");

    // A consumed end-of-string word leaves no sequence state behind
    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.eos) |=>
        (r_pend == '0 && r_skip == '0 && !r_halted && r_seq == '0))
        else $error("state not cleared after end of string");

    // Error words carry no bit count, characters always do
    a_bits_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_ok && r_bits != '0) || (!r_ok && r_bits == '0)))
        else $error("bit count does not match ok flag");

endmodule

[tb/tb_utf8_byte_stream_decoder.sv]
// Self-checking testbench for the UTF-8 byte stream decoder: directed and random strings.
module tb_utf8_byte_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAIN_CYCLES = 16;      // queue depth plus pipeline, with margin
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned IDLE_PCT     = 21;
    localparam int unsigned PHASE_BYTES  = 320;

    // One decoded character or error marker
    typedef struct packed {
        logic [ubd_pkg::CODE_W-1:0] code;
        logic                       ok;
        logic [ubd_pkg::BITS_W-1:0] bit_count;
    } t_char;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic                         i_cfg_idx;
    logic                         i_cfg_wdata;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [ubd_pkg::OCTET_W-1:0]  i_octet;
    logic                         i_end_of_string;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic [ubd_pkg::CODE_W-1:0]   o_code;
    logic                         o_ok;
    logic [ubd_pkg::BITS_W-1:0]   o_bit_count;

    utf8_byte_stream_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_octet         (i_octet),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_code          (o_code),
        .o_ok            (o_ok),
        .o_bit_count     (o_bit_count)
    );

    // Decoder shadow state and register copies
    logic [ubd_pkg::PEND_W-1:0]  pend_cnt;
    logic [ubd_pkg::CODE_W-1:0]  acc;
    logic [ubd_pkg::BITS_W-1:0]  seq_bits;
    logic [2:0]                  skip_cnt;
    logic                        halted;
    logic                        cfg_wide;
    logic                        cfg_cont;

    t_char              expected_chars[$];
    t_char              head;

    bit                 steady;            // no idle cycles on either side
    int unsigned        hold_cycles;       // long output hold-off request
    int unsigned        mismatches;
    int unsigned        cycle_count;
    int unsigned        n_bytes;
    int unsigned        n_strings;
    int unsigned        n_chars_ok;
    int unsigned        n_markers;

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Expected result for a decoded character, with 16-bit replacement
    function automatic void push_char(input logic [ubd_pkg::CODE_W-1:0] value,
                                      input logic [ubd_pkg::BITS_W-1:0] bits);
        t_char c;
        c.code      = (cfg_wide && value > ubd_pkg::BMP_MAX) ? ubd_pkg::ERR_WIDE : value;
        c.ok        = 1'b1;
        c.bit_count = bits;
        expected_chars.insert(expected_chars.size(), c);
    endfunction

    // Error: replacement marker, or abandon the rest of the string
    function automatic void push_error();
        t_char c;
        if (!cfg_cont) begin
            halted = 1'b1;
        end else begin
            c.code      = cfg_wide ? ubd_pkg::ERR_WIDE : ubd_pkg::ERR_NARROW;
            c.ok        = 1'b0;
            c.bit_count = '0;
            expected_chars.insert(expected_chars.size(), c);
        end
    endfunction

    // Shadow decode of one accepted byte word
    function automatic void decode_octet(input logic [7:0] b, input logic eos);
        int len;
        if (halted) begin
            // dropped until end of string
        end else if (skip_cnt != 0) begin
            skip_cnt = skip_cnt - 1'b1;
        end else if (pend_cnt != 0) begin
            if (b[7:6] == 2'b10) begin
                acc      = {acc[ubd_pkg::CODE_W-7:0], b[5:0]};
                pend_cnt = pend_cnt - 1'b1;
                if (pend_cnt == 0)
                    push_char(acc, seq_bits);
                else if (eos)
                    push_error();
            end else begin
                // bad continuation eats the rest of the nominal length
                skip_cnt = 3'(pend_cnt - 1'b1);
                pend_cnt = '0;
                push_error();
            end
        end else if (!b[7]) begin
            push_char(ubd_pkg::CODE_W'(b[6:0]), ubd_pkg::ASCII_BITS);
        end else if (!b[6] || b >= 8'hFE) begin
            push_error();
        end else begin
            len = 0;
            while (len < 7 && b[7-len])
                len++;
            acc      = '0;
            acc[7:0] = b & (8'hFF >> (len + 1));
            seq_bits = ubd_pkg::BITS_W'(5 * len + 1);
            pend_cnt = ubd_pkg::PEND_W'(len - 1);
            if (eos)
                push_error();
        end
        if (eos) begin
            pend_cnt = '0;
            acc      = '0;
            seq_bits = '0;
            skip_cnt = '0;
            halted   = 1'b0;
        end
    endfunction

    // Offer one byte word and wait until it is taken
    task automatic send_octet(input logic [7:0] b, input logic eos);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_octet         <= b;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_in_stall);
        decode_octet(b, eos);
        n_bytes++;
        if (eos)
            n_strings++;
    endtask

    task automatic send_bytes(input logic [7:0] s[$], input logic eos_last);
        foreach (s[i])
            send_octet(s[i], eos_last && (i == s.size() - 1));
    endtask

    // Let everything drain so registers can be touched
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic wide, input logic cont);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= ubd_pkg::CFG_WIDE_MODE;
        i_cfg_wdata <= wide;
        @(posedge i_clk);
        i_cfg_idx   <= ubd_pkg::CFG_CONT_ERR;
        i_cfg_wdata <= cont;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_wide = wide;
        cfg_cont = cont;
    endtask

    // Short string: mostly well-formed sequences, some noise and broken ones
    task automatic send_random_string(input int max_chars);
        logic [7:0] s[$];
        logic [7:0] b;
        int n_chars, kind, len, n_cont;
        n_chars = $urandom_range(1, max_chars);
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(99);
            len  = (kind < 70) ? $urandom_range(1, 6) : $urandom_range(2, 6);
            if (kind >= 70 && kind < 85) begin
                s.insert(s.size(), 8'($urandom));
                continue;
            end
            if (len == 1)
                s.insert(s.size(), {1'b0, 7'($urandom)});
            else
                s.insert(s.size(),
                         ~(8'hFF >> len) | (8'($urandom) & (8'hFF >> (len + 1))));
            n_cont = (kind < 70) ? len - 1 : $urandom_range(0, len - 2);
            repeat (n_cont)
                s.insert(s.size(), {2'b10, 6'($urandom)});
            if (kind >= 93) begin
                // anything but a continuation byte
                b = 8'($urandom);
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                s.insert(s.size(), b);
            end
        end
        send_bytes(s, 1'b1);
    endtask

    // Extremes of the one-, two- and six-byte sequences and every error kind
    task automatic test_directed_cases();
        logic [7:0] s[$];
        set_mode(1'b0, 1'b1);
        s = {8'h00, 8'h7F, 8'hC2, 8'h80,
             8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
             8'h80, 8'hFE, 8'hFF,
             8'hE0, 8'h41, 8'h41};
        // string ends while the bad continuation tail is dropped
        send_bytes(s, 1'b1);
        // cut-off sequence
        s = {8'hF0, 8'h90};
        send_bytes(s, 1'b1);
        set_mode(1'b1, 1'b0);
        // above the BMP in 16-bit mode, then an error halts the string
        s = {8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'h41, 8'h41};
        send_bytes(s, 1'b1);
        send_octet(8'h41, 1'b1);
    endtask

    // Output held off long enough to fill the queue and stall the input
    task automatic test_output_backpressure();
        logic [7:0] s[$];
        set_mode(1'b0, 1'b1);
        repeat (40)
            s.insert(s.size(), {1'b0, 7'($urandom)});
        steady      = 1'b1;
        hold_cycles = 80;
        send_bytes(s, 1'b1);
        steady      = 1'b0;
    endtask

    // Random strings under every mode setting, one phase without idling
    task automatic test_random_strings();
        logic [1:0] modes[4];
        int unsigned start;
        modes = '{2'b00, 2'b11, 2'b01, 2'b10};
        for (int p = 0; p < 4; p++) begin
            set_mode(modes[p][1], modes[p][0]);
            steady = (p == 2);
            start  = n_bytes;
            while (n_bytes - start < PHASE_BYTES)
                send_random_string(8);
        end
        steady = 1'b0;
    endtask

    // Output side: random stalls, plus an occasional long hold-off
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end
            i_out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected result: code=%h ok=%b bit_count=%0d",
                       o_code, o_ok, o_bit_count);
                mismatches++;
            end else begin
                head = expected_chars.pop_front();
                if (o_code !== head.code) begin
                    $error("code: expected %h, got %h", head.code, o_code);
                    mismatches++;
                end
                if (o_ok !== head.ok) begin
                    $error("ok: expected %b, got %b", head.ok, o_ok);
                    mismatches++;
                end
                if (o_bit_count !== head.bit_count) begin
                    $error("bit_count: expected %0d, got %0d", head.bit_count, o_bit_count);
                    mismatches++;
                end
                if (head.ok)
                    n_chars_ok++;
                else
                    n_markers++;
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d results outstanding",
                 expected_chars.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = ubd_pkg::CFG_WIDE_MODE;
        i_cfg_wdata     = 1'b0;
        i_in_valid      = 1'b0;
        i_octet         = '0;
        i_end_of_string = 1'b0;
        steady          = 1'b0;
        hold_cycles     = 0;
        mismatches      = 0;
        n_bytes         = 0;
        n_strings       = 0;
        n_chars_ok      = 0;
        n_markers       = 0;
        pend_cnt        = '0;
        acc             = '0;
        seq_bits        = '0;
        skip_cnt        = '0;
        halted          = 1'b0;
        cfg_wide        = 1'b0;
        cfg_cont        = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_output_backpressure();
        test_random_strings();
        wait_idle();

        $display("Sent %0d bytes in %0d strings; checked %0d characters and %0d error markers",
                 n_bytes, n_strings, n_chars_ok, n_markers);
        $display("Covered all four mode settings, a long output hold-off and an unthrottled phase");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
